/* hw/rtl/xxh32_pkg.sv */
package xxh32_pkg;

    localparam logic [31:0] PRIME1 = 32'h9E37_79B1;
    localparam logic [31:0] PRIME2 = 32'h85EB_CA77;
    localparam logic [31:0] PRIME3 = 32'hC2B2_AE3D;
    localparam logic [31:0] PRIME4 = 32'h27D4_EB2F;
    localparam logic [31:0] PRIME5 = 32'h1656_67B1;

    // rotate and shift amounts of the scheme
    localparam int unsigned ROT_ROUND = 13;
    localparam int unsigned ROT_WORD  = 17;
    localparam int unsigned ROT_BYTE  = 11;
    localparam int unsigned ROT_LANE0 = 1;
    localparam int unsigned ROT_LANE1 = 7;
    localparam int unsigned ROT_LANE2 = 12;
    localparam int unsigned ROT_LANE3 = 18;
    localparam int unsigned SHR_AV1   = 15;
    localparam int unsigned SHR_AV2   = 13;
    localparam int unsigned SHR_AV3   = 16;

    typedef enum logic [11:0] {
        ST_IDLE      = 12'b0000_0000_0001,
        ST_LANE_MUL  = 12'b0000_0000_0010,
        ST_LANE_MIX  = 12'b0000_0000_0100,
        ST_LANE_TAKE = 12'b0000_0000_1000,
        ST_START     = 12'b0000_0001_0000,
        ST_MERGE     = 12'b0000_0010_0000,
        ST_FOLD      = 12'b0000_0100_0000,
        ST_FOLD_MIX  = 12'b0000_1000_0000,
        ST_FOLD_TAKE = 12'b0001_0000_0000,
        ST_AV_A      = 12'b0010_0000_0000,
        ST_AV_B      = 12'b0100_0000_0000,
        ST_AV_C      = 12'b1000_0000_0000
    } state_t;

    // operands handed to the shared multiplier
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } mul_req_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
        logic [4:0] s;
        s = r[4:0];
        if (s == 5'd0)
            return x;
        return (x << s) | (x >> (6'd32 - {1'b0, s}));
    endfunction

    // merge rotation of each lane
    function automatic logic [31:0] lane_rot(input logic [31:0] x, input logic [1:0] lane);
        logic [31:0] y;
        case (lane)
            2'd0:    y = rotl32(x, ROT_LANE0);
            2'd1:    y = rotl32(x, ROT_LANE1);
            2'd2:    y = rotl32(x, ROT_LANE2);
            default: y = rotl32(x, ROT_LANE3);
        endcase
        return y;
    endfunction

endpackage

/* hw/rtl/xxh32_mul.sv */
module xxh32_mul
(
    input  logic                clk,
    input  xxh32_pkg::mul_req_t req,
    output logic [31:0]         product
);

    logic [63:0] full_prod;
    logic [31:0] product_reg;

    // low word of the product, registered: it appears in the cycle after the operands
    assign full_prod = {32'd0, req.a} * {32'd0, req.b};

    always_ff @(posedge clk)
    begin
        product_reg <= full_prod[31:0];
    end

    assign product = product_reg;

endmodule

/* hw/rtl/xxhash32_byte_stream.sv */
// xxhash32 over a byte stream, one byte per input word, seed in a config register
// a byte that neither fills a stripe nor ends the message leaves the block idle and ready for the next byte
// a completed stripe runs 4 lanes in turn on the one shared multiplier, each through LANE_MUL, LANE_MIX, LANE_TAKE
// finish: start, merge of lanes 1 to 3 (only after a stripe), fold of each leftover word then byte, avalanche
// each step waits on the multiplier's registered product; input stalls until the stripe is absorbed or the hash is out
// reset sets the state to idle and clears counts and seed to zero; stripe buffer, lanes, h and hash hold no reset value
module xxhash32_byte_stream
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration: hash seed
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,

    // input words
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        empty_message,

    // result words
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] hash_value
);

    // control state
    xxh32_pkg::state_t state_reg, state_next;
    logic [31:0] seed_reg, seed_next;
    logic [3:0]  fill_reg, fill_next;
    logic [31:0] length_reg, length_next;
    logic        seen_reg, seen_next;
    logic        pend_last_reg, pend_last_next;
    logic [1:0]  lane_reg, lane_next;
    logic [3:0]  pos_reg, pos_next;
    logic        is_word_reg, is_word_next;
    logic        out_valid_reg, out_valid_next;

    // payload state
    logic [31:0] stripe_reg [4];
    logic [31:0] stripe_next [4];
    logic [31:0] acc_reg [4];
    logic [31:0] acc_next [4];
    logic [31:0] h_reg, h_next;
    logic [31:0] hash_reg, hash_next;

    // shared multiplier
    xxh32_pkg::mul_req_t mul_req;
    logic [31:0]         product;

    // one read port on the stripe buffer: a word, and a byte picked from it
    logic [1:0]  word_idx;
    logic [31:0] rd_word;
    logic [31:0] rd_byte;
    logic [4:0]  pos_plus4;
    logic [31:0] mix;
    logic        accept;

    xxh32_mul u_mul
    (
        .clk     (clk),
        .req     (mul_req),
        .product (product)
    );

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != xxh32_pkg::ST_IDLE);

    assign word_idx  = (state_reg == xxh32_pkg::ST_FOLD) ? pos_reg[3:2] : lane_reg;
    assign rd_word   = stripe_reg[word_idx];
    assign rd_byte   = {24'd0, rd_word[{pos_reg[1:0], 3'b000} +: 8]};
    assign pos_plus4 = {1'b0, pos_reg} + 5'd4;

    always_comb
    begin
        state_next     = state_reg;
        seed_next      = seed_reg;
        fill_next      = fill_reg;
        length_next    = length_reg;
        seen_next      = seen_reg;
        pend_last_next = pend_last_reg;
        lane_next      = lane_reg;
        pos_next       = pos_reg;
        is_word_next   = is_word_reg;
        out_valid_next = out_valid_reg;
        stripe_next    = stripe_reg;
        acc_next       = acc_reg;
        h_next         = h_reg;
        hash_next      = hash_reg;
        mul_req.a      = rd_word;
        mul_req.b      = xxh32_pkg::PRIME2;
        mix            = 32'd0;

        if (cfg_wr_en)
        begin
            seed_next = cfg_wr_data;
        end

        // result taken downstream
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            xxh32_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (empty_message)
                    begin
                        // drop any partial message, hash the empty one
                        fill_next   = 4'd0;
                        length_next = 32'd0;
                        seen_next   = 1'b0;
                        state_next  = xxh32_pkg::ST_START;
                    end
                    else
                    begin
                        stripe_next[fill_reg[3:2]][{fill_reg[1:0], 3'b000} +: 8] = data_byte;
                        fill_next      = fill_reg + 4'd1;
                        length_next    = length_reg + 32'd1;
                        pend_last_next = last_byte;
                        if (fill_reg == 4'd15)
                        begin
                            // stripe complete: seed the lanes on the first one
                            if (!seen_reg)
                            begin
                                acc_next[0] = seed_reg + xxh32_pkg::PRIME1 + xxh32_pkg::PRIME2;
                                acc_next[1] = seed_reg + xxh32_pkg::PRIME2;
                                acc_next[2] = seed_reg;
                                acc_next[3] = seed_reg - xxh32_pkg::PRIME1;
                                seen_next   = 1'b1;
                            end
                            lane_next  = 2'd0;
                            state_next = xxh32_pkg::ST_LANE_MUL;
                        end
                        else if (last_byte)
                        begin
                            state_next = xxh32_pkg::ST_START;
                        end
                    end
                end
            end

            // lane round: word * prime2, add, rotate, * prime1
            xxh32_pkg::ST_LANE_MUL:
            begin
                mul_req.a  = rd_word;
                mul_req.b  = xxh32_pkg::PRIME2;
                state_next = xxh32_pkg::ST_LANE_MIX;
            end

            xxh32_pkg::ST_LANE_MIX:
            begin
                mix        = xxh32_pkg::rotl32(acc_reg[lane_reg] + product, xxh32_pkg::ROT_ROUND);
                mul_req.a  = mix;
                mul_req.b  = xxh32_pkg::PRIME1;
                state_next = xxh32_pkg::ST_LANE_TAKE;
            end

            xxh32_pkg::ST_LANE_TAKE:
            begin
                acc_next[lane_reg] = product;
                if (lane_reg == 2'd3)
                begin
                    state_next = pend_last_reg ? xxh32_pkg::ST_START : xxh32_pkg::ST_IDLE;
                end
                else
                begin
                    lane_next  = lane_reg + 2'd1;
                    state_next = xxh32_pkg::ST_LANE_MUL;
                end
            end

            // start value plus length
            xxh32_pkg::ST_START:
            begin
                pos_next = 4'd0;
                if (seen_reg)
                begin
                    h_next     = length_reg + xxh32_pkg::lane_rot(acc_reg[0], 2'd0);
                    lane_next  = 2'd1;
                    state_next = xxh32_pkg::ST_MERGE;
                end
                else
                begin
                    h_next     = length_reg + seed_reg + xxh32_pkg::PRIME5;
                    state_next = xxh32_pkg::ST_FOLD;
                end
            end

            xxh32_pkg::ST_MERGE:
            begin
                h_next = h_reg + xxh32_pkg::lane_rot(acc_reg[lane_reg], lane_reg);
                if (lane_reg == 2'd3)
                begin
                    state_next = xxh32_pkg::ST_FOLD;
                end
                else
                begin
                    lane_next = lane_reg + 2'd1;
                end
            end

            // whole leftover words first, then single bytes
            xxh32_pkg::ST_FOLD:
            begin
                if (pos_plus4 <= {1'b0, fill_reg})
                begin
                    mul_req.a    = rd_word;
                    mul_req.b    = xxh32_pkg::PRIME3;
                    is_word_next = 1'b1;
                    state_next   = xxh32_pkg::ST_FOLD_MIX;
                end
                else if (pos_reg < fill_reg)
                begin
                    mul_req.a    = rd_byte;
                    mul_req.b    = xxh32_pkg::PRIME5;
                    is_word_next = 1'b0;
                    state_next   = xxh32_pkg::ST_FOLD_MIX;
                end
                else
                begin
                    state_next = xxh32_pkg::ST_AV_A;
                end
            end

            xxh32_pkg::ST_FOLD_MIX:
            begin
                if (is_word_reg)
                begin
                    mix       = xxh32_pkg::rotl32(h_reg + product, xxh32_pkg::ROT_WORD);
                    mul_req.b = xxh32_pkg::PRIME4;
                end
                else
                begin
                    mix       = xxh32_pkg::rotl32(h_reg + product, xxh32_pkg::ROT_BYTE);
                    mul_req.b = xxh32_pkg::PRIME1;
                end
                mul_req.a  = mix;
                state_next = xxh32_pkg::ST_FOLD_TAKE;
            end

            xxh32_pkg::ST_FOLD_TAKE:
            begin
                h_next     = product;
                pos_next   = is_word_reg ? pos_reg + 4'd4 : pos_reg + 4'd1;
                state_next = xxh32_pkg::ST_FOLD;
            end

            // avalanche
            xxh32_pkg::ST_AV_A:
            begin
                mul_req.a  = h_reg ^ (h_reg >> xxh32_pkg::SHR_AV1);
                mul_req.b  = xxh32_pkg::PRIME2;
                state_next = xxh32_pkg::ST_AV_B;
            end

            xxh32_pkg::ST_AV_B:
            begin
                mul_req.a  = product ^ (product >> xxh32_pkg::SHR_AV2);
                mul_req.b  = xxh32_pkg::PRIME3;
                h_next     = product ^ (product >> xxh32_pkg::SHR_AV2);
                state_next = xxh32_pkg::ST_AV_C;
            end

            xxh32_pkg::ST_AV_C:
            begin
                // hold the product until the output register is free
                mul_req.a = h_reg;
                mul_req.b = xxh32_pkg::PRIME3;
                if (!(out_valid_reg && out_stall))
                begin
                    hash_next      = product ^ (product >> xxh32_pkg::SHR_AV3);
                    out_valid_next = 1'b1;
                    fill_next      = 4'd0;
                    length_next    = 32'd0;
                    seen_next      = 1'b0;
                    state_next     = xxh32_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = xxh32_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= xxh32_pkg::ST_IDLE;
            seed_reg      <= 32'd0;
            fill_reg      <= 4'd0;
            length_reg    <= 32'd0;
            seen_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            lane_reg      <= 2'd0;
            pos_reg       <= 4'd0;
            is_word_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seed_reg      <= seed_next;
            fill_reg      <= fill_next;
            length_reg    <= length_next;
            seen_reg      <= seen_next;
            pend_last_reg <= pend_last_next;
            lane_reg      <= lane_next;
            pos_reg       <= pos_next;
            is_word_reg   <= is_word_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        stripe_reg <= stripe_next;
        acc_reg    <= acc_next;
        h_reg      <= h_next;
        hash_reg   <= hash_next;
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

    // a final byte always starts finalisation
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_byte) |=> (state_reg != xxh32_pkg::ST_IDLE))
    else $error("final byte did not start finalisation");

    // a plain byte short of a full stripe leaves the block ready
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !last_byte && !empty_message && fill_reg != 4'd15)
        |=> (state_reg == xxh32_pkg::ST_IDLE))
    else $error("plain byte left the block busy");

    // a finished hash waits while the output register is held
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == xxh32_pkg::ST_AV_C && out_valid_reg && out_stall)
        |=> (state_reg == xxh32_pkg::ST_AV_C))
    else $error("hash overwrote a pending result");

endmodule

/* tb/sv/xxh32_hash_checker.sv */
module xxh32_hash_checker
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,

    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        empty_message,

    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] hash_value,

    output int unsigned errors,
    output int unsigned outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam bit [31:0] PRIME_1 = 32'h9E37_79B1;
    localparam bit [31:0] PRIME_2 = 32'h85EB_CA77;
    localparam bit [31:0] PRIME_3 = 32'hC2B2_AE3D;
    localparam bit [31:0] PRIME_4 = 32'h27D4_EB2F;
    localparam bit [31:0] PRIME_5 = 32'h1656_67B1;
    localparam int unsigned STRIPE_LEN = 16;

    bit [31:0]   seed;
    bit [31:0]   lanes [4];
    bit [7:0]    stripe [STRIPE_LEN];
    int unsigned fill;
    bit [31:0]   msg_len;
    bit          have_stripe;
    bit [31:0]   expected_hashes [$];
    bit [31:0]   want;

    function automatic bit [31:0] rol(input bit [31:0] x, input int unsigned r);
        return (x << r) | (x >> (32 - r));
    endfunction

    // little-endian word out of the stripe
    function automatic bit [31:0] word_le(input int unsigned pos);
        return {stripe[pos + 3], stripe[pos + 2], stripe[pos + 1], stripe[pos]};
    endfunction

    function automatic bit [31:0] lane_round(input bit [31:0] acc, input bit [31:0] w);
        return rol(acc + w * PRIME_2, 13) * PRIME_1;
    endfunction

    function automatic bit [31:0] final_hash();
        bit [31:0]   h;
        int unsigned pos;
        pos = 0;
        if (have_stripe)
            h = rol(lanes[0], 1) + rol(lanes[1], 7) + rol(lanes[2], 12) + rol(lanes[3], 18);
        else
            h = seed + PRIME_5;
        h += msg_len;
        while (pos + 4 <= fill)
        begin
            h += word_le(pos) * PRIME_3;
            h = rol(h, 17) * PRIME_4;
            pos += 4;
        end
        while (pos < fill)
        begin
            h += {24'd0, stripe[pos]} * PRIME_5;
            h = rol(h, 11) * PRIME_1;
            pos++;
        end
        h ^= h >> 15;
        h = h * PRIME_2;
        h ^= h >> 13;
        h = h * PRIME_3;
        h ^= h >> 16;
        return h;
    endfunction

    function automatic void clear_msg();
        fill = 0;
        msg_len = 0;
        have_stripe = 1'b0;
    endfunction

    function automatic void absorb_word(input bit [7:0] b, input bit lst, input bit emp);
        if (emp)
        begin
            clear_msg();
            expected_hashes.push_back(final_hash());
            return;
        end
        stripe[fill] = b;
        fill++;
        msg_len++;
        if (fill == STRIPE_LEN)
        begin
            if (!have_stripe)
            begin
                lanes[0] = seed + PRIME_1 + PRIME_2;
                lanes[1] = seed + PRIME_2;
                lanes[2] = seed;
                lanes[3] = seed - PRIME_1;
                have_stripe = 1'b1;
            end
            for (int i = 0; i < 4; i++)
                lanes[i] = lane_round(lanes[i], word_le(4 * i));
            fill = 0;
        end
        if (lst)
        begin
            expected_hashes.push_back(final_hash());
            clear_msg();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed = '0;
            clear_msg();
            expected_hashes.delete();
            errors <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_hashes.size() == 0)
                begin
                    $display("%0t: hash_value expected none actual %h", $time, hash_value);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_hashes.pop_front();
                    if (hash_value !== want)
                    begin
                        $display("%0t: hash_value expected %h actual %h", $time, want, hash_value);
                        errors <= errors + 1;
                    end
                end
            end
            if (cfg_wr_en)
                seed = cfg_wr_data;
            if (in_valid && !in_stall)
                absorb_word(data_byte, last_byte, empty_message);
            outstanding <= expected_hashes.size();
        end
    end

endmodule

/* tb/sv/tb_xxhash32_byte_stream.sv */
module tb_xxhash32_byte_stream;
    timeunit 1ns;
    timeprecision 1ps;

    // random part stops once this many words have gone in
    localparam int unsigned RANDOM_WORDS = 1150;
    // words per seed setting in the random part
    localparam int unsigned PHASE_WORDS = 160;
    // idle time after the drain, long enough for a stripe round and a full finish
    localparam int unsigned SETTLE_CYCLES = 40;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        empty_message;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] hash_value;

    int unsigned errors;
    int unsigned outstanding;
    int unsigned words_sent;

    // idling switches, flipped per phase so some stretches run flat out
    bit          tx_idle;
    bit          rx_idle;

    xxhash32_byte_stream uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .empty_message (empty_message),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hash_value    (hash_value)
    );

    xxh32_hash_checker hash_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .empty_message (empty_message),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hash_value    (hash_value),
        .errors        (errors),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // overall guard against a hung handshake
    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    // result side: when idling is on, stall for a random number of cycles, then take one word
    initial
    begin
        int unsigned hold;
        out_stall = 1'b0;
        wait (rst_n);
        forever
        begin
            hold = rx_idle ? $urandom_range(0, 11) : 0;
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // one input word, with a random gap in front of it when idling is on
    task automatic send_word(input logic [7:0] b, input logic lst, input logic emp);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 11) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        last_byte     <= lst;
        empty_message <= emp;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
    endtask

    // n random bytes, the final one marked last when close is set
    task automatic send_bytes(input int unsigned n, input bit close);
        for (int unsigned i = 1; i <= n; i++)
            send_word(8'($urandom_range(0, 255)), close && (i == n), 1'b0);
    endtask

    // empty flag with junk on the ignored fields
    task automatic send_empty();
        send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    endtask

    // drop valid, wait for every hash to drain and the block to go quiet
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // mostly whole messages, weighted towards stripe boundaries,
    // with some bare empties and some messages cut short by an empty
    task automatic send_message();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            send_empty();
        else if (pick < 14)
        begin
            send_bytes($urandom_range(1, 40), 1'b0);
            send_empty();
        end
        else if (pick < 60)
            send_bytes($urandom_range(1, 15), 1'b1);
        else if (pick < 74)
            send_bytes(16 * $urandom_range(1, 3) + $urandom_range(0, 2) - 1, 1'b1);
        else if (pick < 94)
            send_bytes($urandom_range(17, 64), 1'b1);
        else
            send_bytes($urandom_range(65, 120), 1'b1);
    endtask

    initial
    begin
        int unsigned phase;
        int unsigned phase_start;
        bit          carry;

        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        in_valid      = 1'b0;
        data_byte     = '0;
        last_byte     = 1'b0;
        empty_message = 1'b0;
        tx_idle       = 1'b0;
        rx_idle       = 1'b0;
        words_sent    = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme bytes, short messages, empty flag
        write_seed(32'h0000_0000);
        send_word(8'hA5, 1'b1, 1'b1);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'h80, 1'b0, 1'b0);
        send_word(8'h7F, 1'b1, 1'b0);
        settle();
        write_seed(32'hFFFF_FFFF);
        send_word(8'h00, 1'b0, 1'b1);

        // seed changed part way through a short message: finish takes the new one
        send_bytes(3, 1'b0);
        settle();
        write_seed(32'h1234_5678);
        send_bytes(2, 1'b1);

        // partial message thrown away by an empty flag
        send_bytes(3, 1'b0);
        send_empty();

        // random phases, each under its own seed; a message may straddle the
        // seed write so lanes pick up whatever seed is live at the first stripe
        words_sent = 0;
        phase      = 0;
        carry      = 1'b0;
        while (words_sent < RANDOM_WORDS)
        begin
            settle();
            case (phase % 4)
                0:       write_seed(32'hFFFF_FFFF);
                1:       write_seed(32'h0000_0000);
                default: write_seed($urandom);
            endcase
            tx_idle = (phase % 3 != 1);
            rx_idle = (phase % 3 != 2);
            if (carry)
            begin
                send_bytes($urandom_range(1, 20), 1'b1);
                carry = 1'b0;
            end
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS && words_sent < RANDOM_WORDS)
                send_message();
            if ($urandom_range(0, 1) != 0)
            begin
                send_bytes($urandom_range(1, 30), 1'b0);
                carry = 1'b1;
            end
            phase++;
        end
        if (carry)
            send_bytes($urandom_range(1, 20), 1'b1);

        // drain, then leave room for any stray hash
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (errors == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/xxh32_pkg.sv
hw/rtl/xxh32_mul.sv
hw/rtl/xxhash32_byte_stream.sv
tb/sv/xxh32_hash_checker.sv
tb/sv/tb_xxhash32_byte_stream.sv
